// ----- sv/lgrs_pkg.sv -----
// lgrs_pkg: shared constants, types and the life rule for the row stepper
// no dependencies; used by every module of the block
`default_nettype none

package lgrs_pkg;

  localparam int ROW_W       = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int WIDTH_W     = 7;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(64);

  // one queued unit of work: the three rows around the held row plus flags
  typedef struct packed {
    logic [ROW_W-1:0] up;
    logic [ROW_W-1:0] mid;
    logic [ROW_W-1:0] cur;
    logic             emit_mid;
    logic             last;
  } lgrs_job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } lgrs_q_status_t;

  // mask of the cells in use, width saturated at the column limit
  function automatic logic [ROW_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] sat;
    logic [ROW_W:0]     sh;
    sat = (w > WIDTH_W'(MAX_COLUMNS)) ? WIDTH_W'(MAX_COLUMNS) : w;
    sh  = {{ROW_W{1'b0}}, 1'b1} << sat;
    sh  = sh - {{ROW_W{1'b0}}, 1'b1};
    return sh[ROW_W-1:0];
  endfunction

  // b3/s23 rule on one row, dead cells beyond the edges
  function automatic logic [ROW_W-1:0] life_row(input logic [ROW_W-1:0] up,
                                                input logic [ROW_W-1:0] mid,
                                                input logic [ROW_W-1:0] dn,
                                                input logic [WIDTH_W-1:0] w);
    logic [ROW_W-1:0] m;
    logic [ROW_W+1:0] u_p;
    logic [ROW_W+1:0] m_p;
    logic [ROW_W+1:0] d_p;
    logic [ROW_W-1:0] res;
    logic [3:0]       n;
    m   = width_mask(w);
    u_p = {1'b0, up & m, 1'b0};
    m_p = {1'b0, mid & m, 1'b0};
    d_p = {1'b0, dn & m, 1'b0};
    res = '0;
    for (int c = 0; c < ROW_W; c++) begin
      n = 4'(u_p[c]) + 4'(u_p[c+1]) + 4'(u_p[c+2])
        + 4'(d_p[c]) + 4'(d_p[c+1]) + 4'(d_p[c+2])
        + 4'(m_p[c]) + 4'(m_p[c+2]);
      res[c] = (n == 4'd3) || ((n == 4'd2) && m_p[c+1]);
    end
    return res & m;
  endfunction

endpackage

`default_nettype wire

// ----- sv/lgrs_row_if.sv -----
// lgrs_row_if: input channel carrying one grid row per word
// depends on lgrs_pkg
`default_nettype none

interface lgrs_row_if
  import lgrs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_cells;
  logic             first_row;
  logic             last_row;

  modport source (output valid, output row_cells, output first_row, output last_row,
                  input ready);
  modport sink   (input valid, input row_cells, input first_row, input last_row,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/lgrs_res_if.sv -----
// lgrs_res_if: output channel carrying one next-generation row per word
// depends on lgrs_pkg
`default_nettype none

interface lgrs_res_if
  import lgrs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] next_row;
  logic             frame_end;

  modport source (output valid, output next_row, output frame_end, input ready);
  modport sink   (input valid, input next_row, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- sv/lgrs_front.sv -----
// lgrs_front: accepts input rows, keeps the row window, builds jobs for the queue
// depends on lgrs_pkg and lgrs_row_if
`default_nettype none

module lgrs_front
  import lgrs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lgrs_row_if.sink      row_i,
  input  lgrs_q_status_t q_stat_i,
  output logic          push_o,
  output lgrs_job_t     job_o
);

  logic [ROW_W-1:0] above_q, above_d;
  logic [ROW_W-1:0] middle_q, middle_d;
  logic             mid_valid_q, mid_valid_d;
  logic             accept;
  logic             eff_valid;

  // take a word whenever the queue has room
  assign row_i.ready = !q_stat_i.full;
  assign accept      = row_i.valid && row_i.ready;

  // a first-row mark drops any held row
  assign eff_valid = mid_valid_q && !row_i.first_row;

  // job for this word
  always_comb begin
    job_o.up       = above_q;
    job_o.mid      = middle_q;
    job_o.cur      = row_i.row_cells;
    job_o.emit_mid = eff_valid;
    job_o.last     = row_i.last_row;
    push_o         = accept && (eff_valid || row_i.last_row);
  end

  // window update
  always_comb begin
    above_d     = above_q;
    middle_d    = middle_q;
    mid_valid_d = mid_valid_q;
    if (accept) begin
      if (row_i.last_row) begin
        above_d     = '0;
        middle_d    = '0;
        mid_valid_d = 1'b0;
      end else begin
        above_d     = eff_valid ? middle_q : '0;
        middle_d    = row_i.row_cells;
        mid_valid_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= mid_valid_d;
    end
  end

  // row data
  always_ff @(posedge clk_i) begin
    above_q  <= above_d;
    middle_q <= middle_d;
  end

endmodule

`default_nettype wire

// ----- sv/lgrs_fifo.sv -----
// lgrs_fifo: two-entry job queue between front and back
// depends on lgrs_pkg
`default_nettype none

module lgrs_fifo
  import lgrs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  logic           push_i,
  input  lgrs_job_t      job_i,
  input  logic           pop_i,
  output lgrs_job_t      head_o,
  output lgrs_q_status_t stat_o
);

  lgrs_job_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // no overflow, no underflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i) else $error("lgrs_fifo: push while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> !pop_i) else $error("lgrs_fifo: pop while empty");

endmodule

`default_nettype wire

// ----- sv/lgrs_back.sv -----
// lgrs_back: evaluates queued jobs with the life rule into the output register
// depends on lgrs_pkg and lgrs_res_if
`default_nettype none

module lgrs_back
  import lgrs_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  logic [WIDTH_W-1:0]  row_width_i,
  input  lgrs_job_t           head_i,
  input  lgrs_q_status_t      q_stat_i,
  output logic                pop_o,
  lgrs_res_if.source          res_o
);

  logic             phase_q, phase_d;
  logic             out_valid_q, out_valid_d;
  logic [ROW_W-1:0] next_row_q;
  logic             frame_end_q;
  logic             head_valid;
  logic             load;
  logic             job_a;
  logic             entry_done;
  logic [ROW_W-1:0] sel_up, sel_mid, sel_dn;
  logic [ROW_W-1:0] new_row;

  assign head_valid = !q_stat_i.empty;
  assign load       = head_valid && (!out_valid_q || res_o.ready);

  // held row first, then the bottom row of the frame
  assign job_a      = head_i.emit_mid && !phase_q;
  assign entry_done = !job_a || !head_i.last;
  assign pop_o      = load && entry_done;

  // operand select and rule
  always_comb begin
    if (job_a) begin
      sel_up  = head_i.up;
      sel_mid = head_i.mid;
      sel_dn  = head_i.cur;
    end else begin
      sel_up  = head_i.emit_mid ? head_i.mid : '0;
      sel_mid = head_i.cur;
      sel_dn  = '0;
    end
    new_row = life_row(sel_up, sel_mid, sel_dn, row_width_i);
  end

  // control next state
  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      phase_d     = !entry_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      next_row_q  <= new_row;
      frame_end_q <= !job_a;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.next_row  = next_row_q;
  assign res_o.frame_end = frame_end_q;

  // second half of a job only for a last row that also closed a held row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (head_valid && head_i.last && head_i.emit_mid))
    else $error("lgrs_back: second phase without matching job");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !entry_done) |=> (phase_q && !pop_o ? 1'b1 : phase_q))
    else $error("lgrs_back: phase not entered after first half");

endmodule

`default_nettype wire

// ----- sv/life_generation_row_stepper_unit.sv -----
// life_generation_row_stepper_unit: top level of the life row stepper
// depends on lgrs_pkg, lgrs_row_if, lgrs_res_if, lgrs_front, lgrs_fifo, lgrs_back
//
//   channel   dir  handshake      payload
//   row_i     in   valid/ready    row_cells[63:0], first_row, last_row
//   res_o     out  valid/ready    next_row[63:0], frame_end
//   cfg       in   row_width_we_i row_width_i[6:0]
//
// one row per cycle while the queue has room and res_o is ready; a last row that
// closes a held row yields two words and holds the back end for both, set by the
// single rule unit; the queue head job is loaded into the output register
// a two-entry queue lets input words keep flowing while an output word waits
// reset invalidates the held row, clears the queue and output valid; width returns to 64
`default_nettype none

module life_generation_row_stepper_unit
  import lgrs_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  logic               row_width_we_i,
  input  logic [WIDTH_W-1:0] row_width_i,
  lgrs_row_if.sink           row_i,
  lgrs_res_if.source         res_o
);

  logic [WIDTH_W-1:0] row_width_q;
  logic               push;
  logic               pop;
  lgrs_job_t          job;
  lgrs_job_t          head;
  lgrs_q_status_t     q_stat;

  // width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= WIDTH_RESET;
    end else if (row_width_we_i) begin
      row_width_q <= row_width_i;
    end
  end

  lgrs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .row_i    (row_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (job)
  );

  lgrs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  lgrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_width_i (row_width_q),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
